>>> hw/rtl/tmac_pkg.sv
`default_nettype none

package tmac_pkg;

    localparam int DATA_W      = 16;
    localparam int FILL_W      = 7;
    localparam int GAIN_W      = 16;
    localparam int FRAC_W      = 14;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;

    localparam int MEDIAN_TAPS_DEF = 5;
    localparam int AVG_WINDOW_DEF  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_INTERCEPT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USER_OFFSET   = 2'd2;

    localparam logic [GAIN_W-1:0] CAL_GAIN_RST      = 16'd19630;
    localparam logic [DATA_W-1:0] CAL_INTERCEPT_RST = 16'hFE2B;
    localparam logic [DATA_W-1:0] USER_OFFSET_RST   = 16'h0000;

    localparam logic [DATA_W-1:0] SAT_MAX = 16'h7FFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_SUM,
        ST_MAG,
        ST_MUL,
        ST_DIV,
        ST_FINAL,
        ST_OUT
    } tmac_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/tmac_ram.sv
`default_nettype none

module tmac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tmac_median.sv
`default_nettype none

module tmac_median import tmac_pkg::*; #(
    parameter int TAPS = MEDIAN_TAPS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     done,
    output logic signed [DATA_W-1:0] median
);

    localparam int RANK_W = $clog2(TAPS + 1);
    localparam int STEP_W = $clog2(TAPS + 1);
    localparam int MID    = TAPS / 2;

    // The taps form a shift line: a new sample pushes out the oldest one.
    // During the scan the line rotates once around, so the candidate is
    // always the value at tap zero.
    logic signed [DATA_W-1:0] ring_reg  [TAPS];
    logic signed [DATA_W-1:0] ring_next [TAPS];
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] med_reg, med_next;
    logic [RANK_W-1:0]        less_cnt;
    logic [RANK_W-1:0]        equal_cnt;
    logic                     hit;

    always_comb
    begin
        less_cnt  = '0;
        equal_cnt = '0;
        for (int j = 0; j < TAPS; j++)
        begin
            if (ring_reg[j] < ring_reg[0])
            begin
                less_cnt = less_cnt + RANK_W'(1);
            end
            if (ring_reg[j] == ring_reg[0])
            begin
                equal_cnt = equal_cnt + RANK_W'(1);
            end
        end
    end

    // The candidate sits at the middle rank when it spans that position
    // among the sorted values.
    assign hit = (less_cnt <= RANK_W'(MID)) && (RANK_W'(MID) < (less_cnt + equal_cnt));

    always_comb
    begin
        ring_next = ring_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        med_next  = med_reg;
        if (start)
        begin
            ring_next[0] = sample;
            for (int i = 1; i < TAPS; i++)
            begin
                ring_next[i] = ring_reg[i-1];
            end
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            ring_next[0] = ring_reg[TAPS-1];
            for (int i = 1; i < TAPS; i++)
            begin
                ring_next[i] = ring_reg[i-1];
            end
            if (hit)
            begin
                med_next = ring_reg[0];
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(TAPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                ring_reg[i] <= '0;
            end
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ring_reg <= ring_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg <= med_next;
    end

    assign done   = done_reg;
    assign median = med_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tmac_mul.sv
`default_nettype none

module tmac_mul #(
    parameter int A_W = 19,
    parameter int B_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 done,
    output logic [A_W+B_W-1:0]   product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    // Shift-add, one multiplier bit per cycle from the low end. The
    // multiplier starts in the low half and is shifted out as the product
    // grows into the upper half.
    logic [P_W-1:0]   prod_reg, prod_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [A_W:0]     partial;

    assign partial = {1'b0, prod_reg[P_W-1:B_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        prod_next = prod_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = {{A_W{1'b0}}, b};
            a_next    = a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {partial, prod_reg[B_W-1:1]};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tmac_div.sv
`default_nettype none

module tmac_div #(
    parameter int N_W = 22,
    parameter int D_W = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    // Restoring division, one quotient bit per cycle from the top. The
    // divisor is never zero here.
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     shifted;
    logic [D_W+1:0]   trial;

    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[D_W+1])
            begin
                rem_next = shifted[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/temperature_median_average_calibrate.sv
// Temperature filter: each request carries one raw sample in signed hundredths
// of a degree. The sample enters a MEDIAN_TAPS-deep median line (cleared to
// zero at reset), the median enters an AVG_WINDOW-deep moving average that
// covers only the samples held so far until it fills, and the average is
// calibrated as gain * average + intercept, plus the user offset, rounded to
// nearest (ties away from zero) and saturated to 16 bits signed. Each request
// gives exactly one result, together with the current window fill. One sample
// is in work at a time; on its way from request to result the median scan
// steps through every tap, then the bit-serial multiplier applies the gain one
// multiplier bit at a time, and the bit-serial divider by the fill count gives
// one quotient bit per step. A new request is taken as soon as the previous
// result sits in the output register, even if it has not been taken yet.
// Configuration registers may be written only while no sample is in work.
`default_nettype none

module temperature_median_average_calibrate import tmac_pkg::*; #(
    parameter int MEDIAN_TAPS = MEDIAN_TAPS_DEF,
    parameter int AVG_WINDOW  = AVG_WINDOW_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] raw_temp
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] stable_temp, [22:16] window_fill
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]      cfg_wdata
);

    localparam int PTR_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int CNT_W  = $clog2(AVG_WINDOW + 1);
    localparam int SUM_W  = DATA_W + $clog2(AVG_WINDOW);
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int X_W    = PROD_W + 1;
    localparam int Q_W    = X_W - FRAC_W;
    localparam int RES_W  = Q_W + 2;

    tmac_state_t state_reg, state_next;

    logic [GAIN_W-1:0]        gain_reg;
    logic signed [DATA_W-1:0] icpt_reg;
    logic signed [DATA_W-1:0] ofs_reg;

    logic [PTR_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W:0]   bias_reg, bias_next;
    logic signed [RES_W-1:0]  res_reg, res_next;
    logic [OUT_TDATA_W-1:0]   out_data_reg, out_data_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     med_start;
    logic                     med_done;
    logic signed [DATA_W-1:0] med_val;
    logic                     ram_we;
    logic signed [DATA_W-1:0] ram_rdata;
    logic signed [DATA_W-1:0] old_val;
    logic                     win_full;
    logic [SUM_W-1:0]         mag;
    logic                     mul_start;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_prod;
    logic [X_W-1:0]           rounded;
    logic                     div_start;
    logic                     div_done;
    logic [Q_W-1:0]           div_quot;
    logic                     res_ovf;
    logic [DATA_W-1:0]        sat_val;

    tmac_median #(
        .TAPS (MEDIAN_TAPS)
    ) u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (med_start),
        .sample (signed'(s_axis_tdata[DATA_W-1:0])),
        .done   (med_done),
        .median (med_val)
    );

    tmac_ram #(
        .WIDTH (DATA_W),
        .DEPTH (AVG_WINDOW)
    ) u_avg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (med_val),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    tmac_mul #(
        .A_W (SUM_W),
        .B_W (GAIN_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mag),
        .b       (gain_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    tmac_div #(
        .N_W (Q_W),
        .D_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rounded[X_W-1:FRAC_W]),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Window entries at and beyond the fill count were never written and
    // count as zero.
    assign win_full = (cnt_reg == CNT_W'(AVG_WINDOW));
    assign old_val  = win_full ? ram_rdata : '0;
    assign mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // Adding half the divisor and dropping the fraction bits first gives the
    // same quotient as dividing the full product by count * 2^FRAC_W.
    assign rounded  = {1'b0, mul_prod} + (X_W'(cnt_reg) << (FRAC_W - 1));

    assign res_ovf  = !(&res_reg[RES_W-1:DATA_W-1]) && (|res_reg[RES_W-1:DATA_W-1]);
    assign sat_val  = res_ovf ? (res_reg[RES_W-1] ? SAT_MIN : SAT_MAX)
                              : res_reg[DATA_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        neg_next       = neg_reg;
        bias_next      = bias_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        med_start      = 1'b0;
        ram_we         = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    med_start  = 1'b1;
                    state_next = ST_MEDIAN;
                end
            end
            ST_MEDIAN:
            begin
                if (med_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(med_val);
                ram_we   = 1'b1;
                if (pos_reg == PTR_W'(AVG_WINDOW - 1))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + PTR_W'(1);
                end
                if (!win_full)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                neg_next   = sum_reg[SUM_W-1];
                bias_next  = (DATA_W + 1)'(icpt_reg) + (DATA_W + 1)'(ofs_reg);
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (neg_reg)
                begin
                    res_next = RES_W'(bias_reg) - signed'(RES_W'(div_quot));
                end
                else
                begin
                    res_next = RES_W'(bias_reg) + signed'(RES_W'(div_quot));
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {1'b0, FILL_W'(cnt_reg), sat_val};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= CAL_GAIN_RST;
            icpt_reg      <= CAL_INTERCEPT_RST;
            ofs_reg       <= USER_OFFSET_RST;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAL_GAIN:      gain_reg <= cfg_wdata;
                    REG_CAL_INTERCEPT: icpt_reg <= cfg_wdata;
                    REG_USER_OFFSET:   ofs_reg  <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        bias_reg     <= bias_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tmac_chk.sv
`default_nettype none

module tmac_chk import tmac_pkg::*; #(
    parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Requests taken but whose results have not been taken yet.
    logic [1:0] pending_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_take} - {1'b0, out_take};
        end
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:16] != '0) &&
                          (m_axis_tdata[22:16] <= FILL_W'(AVG_WINDOW)))
        else $error("window fill out of range");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 2'd0)
        else $error("result without a pending request");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !s_axis_tready)
        else $error("second request taken while a sample is in work");

endmodule

bind temperature_median_average_calibrate tmac_chk #(
    .AVG_WINDOW (AVG_WINDOW)
) u_tmac_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
